// ===== hw/rtl/ffca_pkg.sv =====
package ffca_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

    localparam int CHUNK_W    = 8;
    localparam int REQ_W      = 24;
    localparam int CB_W       = 17;
    localparam int CIU_W      = 9;
    localparam int ADDR_W     = 48;
    localparam int STATUS_W   = 2;

    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_CHUNK_BYTES   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHUNKS_IN_USE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_POOL_BASE     = 2'd2;

    localparam logic [CB_W-1:0]   CHUNK_BYTES_RST   = 17'd512;
    localparam logic [CIU_W-1:0]  CHUNKS_IN_USE_RST = 9'd256;
    localparam logic [ADDR_W-1:0] POOL_BASE_RST     = '0;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [REQ_W-1:0]   request_bytes;
        logic [CHUNK_W-1:0] free_first;
        logic [CHUNK_W-1:0] free_last;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHUNK_W-1:0]  first_chunk;
        logic [CHUNK_W-1:0]  last_chunk;
        logic [ADDR_W-1:0]   bus_addr;
    } t_rsp;

    typedef struct packed {
        logic [CB_W-1:0]   chunk_bytes;
        logic [CIU_W-1:0]  chunks_in_use;
        logic [ADDR_W-1:0] pool_base_addr;
    } t_cfg;

    typedef enum logic [1:0] {
        MAP_SCAN,
        MAP_MARK,
        MAP_CLEAR
    } t_map_op;

    typedef struct packed {
        logic    go;
        t_map_op op;
    } t_map_ctl;

    typedef struct packed {
        logic done;
        logic found;
    } t_map_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/ffca_regs.sv =====
module ffca_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffca_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffca_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ffca_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ffca_pkg::t_cfg                 o_cfg
);
    import ffca_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk_bytes    <= CHUNK_BYTES_RST;
            r_cfg.chunks_in_use  <= CHUNKS_IN_USE_RST;
            r_cfg.pool_base_addr <= POOL_BASE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CHUNK_BYTES:   r_cfg.chunk_bytes    <= pwdata[CB_W-1:0];
                REG_CHUNKS_IN_USE: r_cfg.chunks_in_use  <= pwdata[CIU_W-1:0];
                REG_POOL_BASE:     r_cfg.pool_base_addr <= pwdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CHUNK_BYTES:   prdata = APB_DATA_W'(r_cfg.chunk_bytes);
            REG_CHUNKS_IN_USE: prdata = APB_DATA_W'(r_cfg.chunks_in_use);
            REG_POOL_BASE:     prdata = APB_DATA_W'(r_cfg.pool_base_addr);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/ffca_div.sv =====
module ffca_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ffca_pkg::REQ_W-1:0] i_dividend,
    input  logic [ffca_pkg::CB_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [ffca_pkg::REQ_W-1:0] o_quot,
    output logic                      o_rem_nz
);
    import ffca_pkg::*;

    localparam int DIV_CNT_W = $clog2(REQ_W);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [REQ_W-1:0]     r_q;
    logic [CB_W-1:0]      r_rem;
    logic [CB_W-1:0]      r_dvs;

    logic [CB_W:0]        w_trial;
    logic [CB_W:0]        w_sub;
    logic                 w_ge;
    logic [CB_W-1:0]      n_rem;
    logic [REQ_W-1:0]     n_q;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_q[REQ_W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_sub   = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_sub[CB_W-1:0] : w_trial[CB_W-1:0];
        n_q     = {r_q[REQ_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(REQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_q;
    assign o_rem_nz = |r_rem;

endmodule

// ===== hw/rtl/ffca_mul.sv =====
module ffca_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ffca_pkg::IDX_W-1:0]  i_mult,
    input  logic [ffca_pkg::CB_W-1:0]   i_mcand,
    input  logic [ffca_pkg::ADDR_W-1:0] i_base,
    output logic                       o_done,
    output logic [ffca_pkg::ADDR_W-1:0] o_addr
);
    import ffca_pkg::*;

    localparam int PROD_W    = IDX_W + CB_W;
    localparam int MUL_CNT_W = $clog2(IDX_W + 1);

    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]     r_m;
    logic [CB_W-1:0]      r_mc;
    logic [ADDR_W-1:0]    r_base;
    logic [PROD_W-1:0]    r_acc;
    logic [ADDR_W-1:0]    r_addr;

    logic [PROD_W-1:0]    n_acc;

    // msb-first shift and add, one multiplier bit per cycle
    assign n_acc = {r_acc[PROD_W-2:0], 1'b0} + (r_m[IDX_W-1] ? PROD_W'(r_mc) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= i_mult;
            r_mc   <= i_mcand;
            r_base <= i_base;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_m   <= r_m << 1;
            r_acc <= n_acc;
        end
        if (r_fin) begin
            r_addr <= r_base + ADDR_W'(r_acc);
        end
    end

    assign o_done = r_done;
    assign o_addr = r_addr;

endmodule

// ===== hw/rtl/ffca_map.sv =====
module ffca_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffca_pkg::t_map_ctl           i_ctl,
    input  logic [ffca_pkg::CHUNK_W-1:0] i_lo,
    input  logic [ffca_pkg::CHUNK_W-1:0] i_hi,
    input  logic [ffca_pkg::CNT_W-1:0]   i_need,
    input  logic [ffca_pkg::CNT_W-1:0]   i_pool,
    output ffca_pkg::t_map_sts           o_sts,
    output logic [ffca_pkg::IDX_W-1:0]   o_first,
    output logic [ffca_pkg::IDX_W-1:0]   o_last
);
    import ffca_pkg::*;

    localparam int CMP_W = (IDX_W > CHUNK_W) ? IDX_W : CHUNK_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CHUNKS - 1);

    // use map kept as a ring, one chunk passes position zero per cycle while a pass runs
    logic [MAX_CHUNKS-1:0] r_map;
    logic                  r_busy;
    logic                  r_done;
    t_map_op               r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_run;
    logic                  r_found;
    logic [IDX_W-1:0]      r_start;
    logic [IDX_W-1:0]      r_end;
    logic [CHUNK_W-1:0]    r_lo;
    logic [CHUNK_W-1:0]    r_hi;

    logic                  w_bit;
    logic                  w_in_clr;
    logic                  w_in_mark;
    logic                  w_in_pool;
    logic                  n_bit;

    always_comb begin
        w_bit     = r_map[0];
        w_in_clr  = (CMP_W'(r_idx) >= CMP_W'(r_lo)) && (CMP_W'(r_idx) <= CMP_W'(r_hi));
        w_in_mark = r_found && (r_idx >= r_start) && (r_idx <= r_end);
        w_in_pool = CNT_W'(r_idx) < i_pool;
        case (r_op)
            MAP_MARK:  n_bit = w_bit | w_in_mark;
            MAP_CLEAR: n_bit = w_bit & ~w_in_clr;
            default:   n_bit = w_bit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_op    <= MAP_SCAN;
            r_idx   <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.go) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_idx  <= '0;
                r_run  <= '0;
                if (i_ctl.op == MAP_SCAN) begin
                    r_found <= 1'b0;
                end
            end else if (r_busy) begin
                r_map <= {n_bit, r_map[MAX_CHUNKS-1:1]};
                if (r_idx == IDX_LAST) begin
                    r_idx  <= '0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_op == MAP_SCAN && !r_found) begin
                    if (w_bit || !w_in_pool) begin
                        r_run <= '0;
                    end else begin
                        r_run <= r_run + 1'b1;
                        if (r_run + 1'b1 == i_need) begin
                            r_found <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            r_lo <= i_lo;
            r_hi <= i_hi;
        end
        if (r_busy && r_op == MAP_SCAN && !r_found && !w_bit && w_in_pool) begin
            if (r_run == '0) begin
                r_start <= r_idx;
            end
            r_end <= r_idx;
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.found = r_found;
    assign o_first     = r_start;
    assign o_last      = r_end;

endmodule

// ===== hw/rtl/first_fit_chunk_allocator.sv =====
// First-fit allocator over a pool of equal chunks whose use is tracked by a bitmap, all free
// after reset. An allocate transaction (cmd 0) asks for request_bytes; the block needs
// ceil(request_bytes / chunk_bytes) chunks, takes the lowest run of that many free chunks
// among the first chunks_in_use, marks it used and returns first_chunk, last_chunk and
// bus_addr = pool_base_addr + first_chunk * chunk_bytes. Zero bytes returns status 1, no room
// returns status 2 with the other fields zero. A free transaction (cmd 1) clears
// free_first..free_last unchecked and returns status 0. One transaction is worked at a time.
// The use map is a ring that turns one chunk per cycle while a pass runs, one full turn to
// search and one to mark, and the chunk count comes from a one-bit-per-cycle divider of 24
// steps. Registers (64-bit data) sit at byte address 0 (chunk_bytes), 8 (chunks_in_use) and
// 16 (pool_base_addr); write them only while idle.
module first_fit_chunk_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ffca_pkg::t_req                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ffca_pkg::t_rsp                  o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffca_pkg::PADDR_W-1:0]    paddr,
    input  logic [ffca_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ffca_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ffca_pkg::*;

    t_cfg             w_cfg;
    t_map_ctl         w_map_ctl;
    t_map_sts         w_map_sts;
    logic [IDX_W-1:0] w_map_first;
    logic [IDX_W-1:0] w_map_last;
    logic             w_div_start;
    logic             w_div_done;
    logic [REQ_W-1:0] w_div_quot;
    logic             w_div_rem_nz;
    logic             w_mul_start;
    logic             w_mul_done;
    logic [ADDR_W-1:0] w_mul_addr;
    logic [CNT_W-1:0] w_pool;
    logic             w_need_big;

    t_state           r_state;
    t_state           n_state;
    t_rsp             r_res;
    t_rsp             n_res;
    logic [CNT_W-1:0] r_need;
    logic [CNT_W-1:0] n_need;
    logic             n_out_load;
    logic             r_out_valid;
    t_rsp             r_out;

    ffca_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ffca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_data.request_bytes),
        .i_divisor  (w_cfg.chunk_bytes),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem_nz   (w_div_rem_nz)
    );

    ffca_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_map_ctl),
        .i_lo    (i_in_data.free_first),
        .i_hi    (i_in_data.free_last),
        .i_need  (r_need),
        .i_pool  (w_pool),
        .o_sts   (w_map_sts),
        .o_first (w_map_first),
        .o_last  (w_map_last)
    );

    ffca_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_mult  (w_map_first),
        .i_mcand (w_cfg.chunk_bytes),
        .i_base  (w_cfg.pool_base_addr),
        .o_done  (w_mul_done),
        .o_addr  (w_mul_addr)
    );

    always_comb begin
        if (32'(w_cfg.chunks_in_use) > 32'(MAX_CHUNKS)) begin
            w_pool = CNT_W'(MAX_CHUNKS);
        end else begin
            w_pool = CNT_W'(w_cfg.chunks_in_use);
        end
        w_need_big = (32'(w_div_quot) > 32'(w_pool))
                  || ((32'(w_div_quot) == 32'(w_pool)) && w_div_rem_nz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_need       = r_need;
        n_out_load   = 1'b0;
        w_map_ctl.go = 1'b0;
        w_map_ctl.op = MAP_SCAN;
        w_div_start  = 1'b0;
        w_mul_start  = 1'b0;
        o_in_stall   = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.cmd == CMD_FREE) begin
                        w_map_ctl.go = 1'b1;
                        w_map_ctl.op = MAP_CLEAR;
                        n_state      = S_FREE;
                    end else if (i_in_data.request_bytes == '0) begin
                        n_res   = '{status: ST_INVALID, default: '0};
                        n_state = S_OUT;
                    end else if (w_cfg.chunk_bytes == '0) begin
                        n_res   = '{status: ST_NOMEM, default: '0};
                        n_state = S_OUT;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_need_big) begin
                    n_res   = '{status: ST_NOMEM, default: '0};
                    n_state = S_OUT;
                end else begin
                    n_need       = CNT_W'(w_div_quot) + CNT_W'(w_div_rem_nz);
                    w_map_ctl.go = 1'b1;
                    w_map_ctl.op = MAP_SCAN;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_map_sts.done) begin
                    if (w_map_sts.found) begin
                        w_map_ctl.go      = 1'b1;
                        w_map_ctl.op      = MAP_MARK;
                        w_mul_start       = 1'b1;
                        n_res.status      = ST_OK;
                        n_res.first_chunk = CHUNK_W'(w_map_first);
                        n_res.last_chunk  = CHUNK_W'(w_map_last);
                        n_res.bus_addr    = '0;
                        n_state           = S_MARK;
                    end else begin
                        n_res   = '{status: ST_NOMEM, default: '0};
                        n_state = S_OUT;
                    end
                end
            end
            S_MARK: begin
                if (w_map_sts.done) begin
                    n_res.bus_addr = w_mul_addr;
                    n_state        = S_OUT;
                end
            end
            S_FREE: begin
                if (w_map_sts.done) begin
                    n_res   = '{status: ST_OK, default: '0};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_need <= n_need;
        if (n_out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_alloc_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_data.cmd == CMD_ALLOC
         && i_in_data.request_bytes != '0 && w_cfg.chunk_bytes != '0)
        |=> r_state == S_DIV)
        else $error("allocate did not start the divider");

    a_map_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_map_sts.done |-> (r_state == S_SCAN || r_state == S_MARK || r_state == S_FREE))
        else $error("map pass ended outside a map state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == S_MARK)
        else $error("address ready outside mark state");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_load && r_res.status != ST_OK)
        |=> (o_out_data.first_chunk == '0 && o_out_data.last_chunk == '0
             && o_out_data.bus_addr == '0))
        else $error("failed transaction carries nonzero fields");
`endif

endmodule

// ===== tb/first_fit_chunk_allocator_tb.sv =====
module first_fit_chunk_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffca_pkg::*;

    class alloc_checker;
        logic [CB_W-1:0]     cb;
        logic [CIU_W-1:0]    ciu;
        logic [ADDR_W-1:0]   base;
        bit [MAX_CHUNKS-1:0] used_map;
        t_rsp                want_rsp[$];
        bit [15:0]           live_runs[$];
        int                  errors;
        int                  printed;

        function new();
            cb = CHUNK_BYTES_RST;
            ciu = CHUNKS_IN_USE_RST;
            base = POOL_BASE_RST;
            used_map = '0;
            errors = 0;
            printed = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
            case (idx)
                REG_CHUNK_BYTES: begin
                    cb = val[CB_W-1:0];
                end
                REG_CHUNKS_IN_USE: begin
                    ciu = val[CIU_W-1:0];
                end
                REG_POOL_BASE: begin
                    base = val[ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int pool_chunks();
            return (ciu > MAX_CHUNKS) ? MAX_CHUNKS : int'(ciu);
        endfunction

        function t_rsp predict_alloc(logic [REQ_W-1:0] size);
            t_rsp              rsp;
            int                pool;
            int                run;
            int                start;
            longint unsigned   sz;
            longint unsigned   cbl;
            longint unsigned   need;
            rsp = '0;
            pool = pool_chunks();
            sz = size;
            cbl = cb;
            run = 0;
            start = 0;
            if (size == 0) begin
                rsp.status = ST_INVALID;
                return rsp;
            end
            rsp.status = ST_NOMEM;
            if (cbl == 0 || sz > longint'(pool) * cbl) return rsp;
            need = (sz + cbl - 1) / cbl;
            for (int i = 0; i < pool; i++) begin
                if (used_map[i]) begin
                    run = 0;
                    continue;
                end
                if (run == 0) start = i;
                run++;
                if (run == need) begin
                    for (int k = start; k <= i; k++) used_map[k] = 1'b1;
                    rsp.status = ST_OK;
                    rsp.first_chunk = CHUNK_W'(start);
                    rsp.last_chunk = CHUNK_W'(i);
                    rsp.bus_addr = base + ADDR_W'(longint'(start) * cbl);
                    live_runs.push_back({CHUNK_W'(start), CHUNK_W'(i)});
                    return rsp;
                end
            end
            return rsp;
        endfunction

        function t_rsp predict_free(logic [CHUNK_W-1:0] first, logic [CHUNK_W-1:0] last);
            t_rsp rsp;
            rsp = '0;
            rsp.status = ST_OK;
            for (int i = int'(first); i <= int'(last); i++) begin
                if (i < MAX_CHUNKS) used_map[i] = 1'b0;
            end
            return rsp;
        endfunction

        function void take_request(t_req r);
            if (r.cmd == CMD_ALLOC) begin
                want_rsp.push_back(predict_alloc(r.request_bytes));
            end else begin
                want_rsp.push_back(predict_free(r.free_first, r.free_last));
            end
        endfunction

        task report(string msg);
            errors++;
            if (printed < 100) begin
                printed++;
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        task match_response(t_rsp got);
            t_rsp want;
            if (want_rsp.size() == 0) begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            want = want_rsp.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.first_chunk !== want.first_chunk)
                report($sformatf("first_chunk got %0d want %0d",
                                 got.first_chunk, want.first_chunk));
            if (got.last_chunk !== want.last_chunk)
                report($sformatf("last_chunk got %0d want %0d",
                                 got.last_chunk, want.last_chunk));
            if (got.bus_addr !== want.bus_addr)
                report($sformatf("bus_addr got %h want %h", got.bus_addr, want.bus_addr));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_rsp                  o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    hold_req = 1'b0;
    alloc_checker          alloc_chk = new();

    first_fit_chunk_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            alloc_chk.match_response(o_out_data);
    end

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return $urandom_range(1, 3);
        if (sel < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int sender_gap();
        return ($urandom_range(0, 99) < 65) ? 0 : gap_len();
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic t_req alloc_req(logic [REQ_W-1:0] size);
        t_req r;
        r.cmd = CMD_ALLOC;
        r.request_bytes = size;
        r.free_first = CHUNK_W'($urandom);
        r.free_last = CHUNK_W'($urandom);
        return r;
    endfunction

    function automatic t_req free_req(int first, int last);
        t_req r;
        r.cmd = CMD_FREE;
        r.request_bytes = REQ_W'($urandom);
        r.free_first = CHUNK_W'(first);
        r.free_last = CHUNK_W'(last);
        return r;
    endfunction

    // sizes mostly land on a few chunks of the current pool, with edge and noise sizes mixed in
    function automatic logic [REQ_W-1:0] pick_size();
        longint unsigned cbl;
        longint unsigned pool_bytes;
        longint unsigned sz;
        int              pool;
        int              k;
        int              sel;
        cbl = alloc_chk.cb;
        pool = alloc_chk.pool_chunks();
        pool_bytes = longint'(pool) * cbl;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            sz = 0;
        end else if (sel < 15 || pool_bytes == 0) begin
            sz = $urandom & 32'hFF_FFFF;
        end else if (sel < 22) begin
            sz = pool_bytes + $urandom_range(0, 1);
        end else begin
            k = (sel < 85) ? $urandom_range(1, (pool < 8) ? pool : 8) : $urandom_range(1, pool);
            sz = longint'(k - 1) * cbl + $urandom_range(1, int'(cbl));
        end
        if (sz > 64'hFF_FFFF) sz = 64'hFF_FFFF;
        return REQ_W'(sz);
    endfunction

    function automatic t_req pick_item();
        int        sel;
        int        idx;
        bit [15:0] run;
        sel = $urandom_range(0, 99);
        if (sel < 55) return alloc_req(pick_size());
        if (sel < 88 && alloc_chk.live_runs.size() > 0) begin
            idx = $urandom_range(0, alloc_chk.live_runs.size() - 1);
            run = alloc_chk.live_runs[idx];
            alloc_chk.live_runs.delete(idx);
            return free_req(run[15:8], run[7:0]);
        end
        if ($urandom_range(0, 9) == 0) return free_req(0, 255);
        return free_req($urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    task automatic send(t_req r);
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        alloc_chk.take_request(r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        alloc_chk.set_reg(idx, val);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic setup(logic [CB_W-1:0] cb, logic [CIU_W-1:0] ciu, logic [ADDR_W-1:0] base);
        write_reg(REG_CHUNK_BYTES, APB_DATA_W'(cb));
        write_reg(REG_CHUNKS_IN_USE, APB_DATA_W'(ciu));
        write_reg(REG_POOL_BASE, APB_DATA_W'(base));
    endtask

    task automatic drain(int extra);
        i_in_valid <= 1'b0;
        while (alloc_chk.want_rsp.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic run_random(int n, int hold_at);
        int g;
        for (int j = 0; j < n; j++) begin
            if (j == hold_at) hold_req = 1'b1;
            send(pick_item());
            g = sender_gap();
            if (g > 0) begin
                i_in_valid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
    endtask

    // receiver: quiet stretches, short and long stalls, and one long hold-off on request
    initial begin : rx_stall
        int hold;
        int quiet;
        int stall_left;
        bit hold_taken;
        hold = 0;
        quiet = 0;
        stall_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold = 2000;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (quiet > 0) begin
                quiet--;
                i_out_stall <= 1'b0;
            end else begin
                quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 600)
                                                     : $urandom_range(0, 8);
                stall_left = gap_len();
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset pool: 256 chunks of 512 bytes at address zero
        send(alloc_req(0));
        send(alloc_req(1));
        send(alloc_req(512));
        send(alloc_req(513));
        send(alloc_req(24'hFF_FFFF));
        send(alloc_req(24'd131072));
        send(free_req(1, 1));
        send(alloc_req(24'd300));
        send(free_req(3, 2));
        send(alloc_req(24'd1024));
        send(free_req(0, 255));
        send(alloc_req(24'd131072));
        send(alloc_req(24'd1));
        send(free_req(255, 255));
        send(alloc_req(24'd512));
        send(free_req(0, 255));
        send(alloc_req(24'd131073));
        send(alloc_req(24'd131071));
        send(free_req(128, 130));
        send(alloc_req(24'd1537));
        send(alloc_req(24'd1536));
        send(free_req(0, 255));
        drain(8);
        alloc_chk.live_runs.delete();

        setup(17'd1, 9'd1, 48'hFFFF_FFFF_FFFF);
        run_random(40, -1);
        drain(8);
        setup(17'd65536, 9'd256, 48'hFFFF_FF80_0000);
        run_random(150, 60);
        drain(8);
        setup(17'h1_FFFF, 9'h1FF, rand48());
        run_random(110, -1);
        drain(8);
        setup(17'd0, 9'd200, rand48());
        run_random(30, -1);
        drain(8);
        setup(17'd700, 9'd0, rand48());
        run_random(30, -1);
        drain(8);
        setup(CB_W'($urandom_range(1, 4096)), CIU_W'($urandom_range(1, 256)), rand48());
        run_random(200, -1);
        drain(8);
        setup(17'd1, 9'd256, 48'd0);
        run_random(150, -1);
        drain(8);
        setup(17'd64, 9'd16, 48'h1234_5678_9ABC);
        run_random(150, -1);
        drain(600);

        if (alloc_chk.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== first_fit_chunk_allocator.f =====
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_regs.sv
hw/rtl/ffca_div.sv
hw/rtl/ffca_mul.sv
hw/rtl/ffca_map.sv
hw/rtl/first_fit_chunk_allocator.sv
tb/first_fit_chunk_allocator_tb.sv
